[rtl/sorted_key_value_map_core_defines.svh]
// assertion macros shared by the checker
`ifndef SORTED_KEY_VALUE_MAP_CORE_DEFINES_SVH
`define SORTED_KEY_VALUE_MAP_CORE_DEFINES_SVH

// same-cycle implication
`define SKVM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skvm assertion failed");

// next-cycle implication
`define SKVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skvm assertion failed");

`endif

[rtl/skvm_pkg.sv]
`timescale 1ns / 1ps
package skvm_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int CAP_W       = 9;
   localparam int POS_W       = 9;
   localparam int STAT_W      = 3;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(256);

   typedef logic [STAT_W-1:0] status_type;

   localparam status_type STATUS_FOUND     = 3'd0;
   localparam status_type STATUS_NOT_FOUND = 3'd1;
   localparam status_type STATUS_INSERTED  = 3'd2;
   localparam status_type STATUS_DUPLICATE = 3'd3;
   localparam status_type STATUS_FULL      = 3'd4;

   localparam logic OP_SEARCH = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] found_value;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

endpackage

[rtl/sorted_key_value_map_core.sv]
`timescale 1ns / 1ps
// a search makes s binary search probes, each a memory read in PROBE and a compare in CMP
//   (s at most ceil(log2(count+1))); a duplicate insert takes as long as a found search
// insert adds a shift through memory in SHIFT, moving entries from position up one slot
// a full table ends an insert in PROBE; one item at a time, next start taken once busy drops
// the result strobe lasts one cycle and cannot be stalled; throughput bound by memory port
// reset clears entry count and sets capacity to 256; the key/value memory is not cleared
module sorted_key_value_map_core
   import skvm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic [CAP_W-1:0] csr_capacity
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_SHIFT = 2'd3;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] src_ff, src_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   entry_type        mem [TABLE_DEPTH];
   entry_type        rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic [31:0]      limit;
   logic             table_full;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid_calc;

   assign limit      = (32'(capacity_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                            : 32'(capacity_ff);
   assign table_full = 32'(count_ff) >= limit;
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc   = mid_sum[IDX_W:1];

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      capacity_in  = capacity_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      src_in       = src_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_calc;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data_ff;

      if (csr_write_en) begin
         capacity_in = csr_capacity;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (req_ff.op == OP_INSERT && table_full) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{STATUS_FULL, '0, '0};
               state_in     = ST_IDLE;
            end else if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_calc;
               mid_in   = mid_calc;
               state_in = ST_CMP;
            end else if (req_ff.op == OP_SEARCH) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{STATUS_NOT_FOUND, POS_W'(lo_ff), '0};
               state_in     = ST_IDLE;
            end else begin
               pos_in   = lo_ff;
               src_in   = count_ff;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end
         end
         ST_CMP: begin
            if (rd_data_ff.key < req_ff.key) begin
               lo_in    = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_PROBE;
            end else if (rd_data_ff.key > req_ff.key) begin
               hi_in    = CNT_W'(mid_ff);
               state_in = ST_PROBE;
            end else begin
               rsp_valid_in = 1'b1;
               if (req_ff.op == OP_SEARCH) begin
                  rsp_in = '{STATUS_FOUND, POS_W'(mid_ff), rd_data_ff.value};
               end else begin
                  rsp_in = '{STATUS_DUPLICATE, POS_W'(mid_ff), '0};
               end
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            // write back the entry read last cycle one slot higher
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = rd_data_ff;
            end
            if (src_ff > pos_ff) begin
               rd_en        = 1'b1;
               rd_addr      = IDX_W'(src_ff - CNT_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = IDX_W'(src_ff);
               src_in       = src_ff - CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  wr_en        = 1'b1;
                  wr_addr      = IDX_W'(pos_ff);
                  wr_data      = '{req_ff.key, req_ff.entry_value};
                  count_in     = count_ff + CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{STATUS_INSERTED, POS_W'(pos_ff), '0};
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      pos_ff       <= pos_in;
      src_ff       <= src_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   // key/value memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[rtl/skvm_checker.sv]
`timescale 1ns / 1ps
`include "sorted_key_value_map_core_defines.svh"
module skvm_checker
   import skvm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data
);

   // every accepted transfer makes the block busy in the next cycle
   `SKVM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // the result strobe comes exactly when the work ends
   `SKVM_ASSERT_IMPLY(a_done_strobe, clock, reset, $fell(busy) && !$past(reset), rsp_valid)

   `SKVM_ASSERT_IMPLY(a_status_legal, clock, reset, rsp_valid, rsp_data.status <= STATUS_FULL)

   `SKVM_ASSERT_IMPLY(a_value_zero, clock, reset, rsp_valid && rsp_data.status != STATUS_FOUND, rsp_data.found_value == '0)

   `SKVM_ASSERT_IMPLY(a_full_pos, clock, reset, rsp_valid && rsp_data.status == STATUS_FULL, rsp_data.position == '0)

endmodule

bind sorted_key_value_map_core skvm_checker u_skvm_checker (.*);

[test/tb_sorted_key_value_map_core.sv]
`timescale 1ns / 1ps
module tb_sorted_key_value_map_core;
   import skvm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned NUM_PHASES  = 8;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_write_en;
   logic [CAP_W-1:0] csr_capacity;

   int unsigned cycle_count = 0;

   // mirror of the sorted table plus the queue of results still owed by the block
   class map_scoreboard;
      logic [KEY_W-1:0] keys [TABLE_DEPTH];
      logic [VAL_W-1:0] vals [TABLE_DEPTH];
      int unsigned      entry_count;
      int unsigned      insert_limit;
      rsp_type          awaited_results [$];
      int unsigned      mismatches;

      function new();
         entry_count  = 0;
         insert_limit = TABLE_DEPTH;
         mismatches   = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         insert_limit = (cap > TABLE_DEPTH) ? TABLE_DEPTH : cap;
      endfunction

      function bit find_key(logic [KEY_W-1:0] k, output int unsigned where);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = entry_count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < k) begin
               lo = mid + 1;
            end else if (keys[mid] > k) begin
               hi = mid;
            end else begin
               where = mid;
               return 1'b1;
            end
         end
         where = lo;
         return 1'b0;
      endfunction

      function void note_request(req_type r);
         rsp_type     want;
         int unsigned pos;
         int unsigned i;
         want = '0;
         pos  = 0;
         if (r.op == OP_SEARCH) begin
            if (find_key(r.key, pos)) begin
               want.status      = STATUS_FOUND;
               want.found_value = vals[pos];
            end else begin
               want.status = STATUS_NOT_FOUND;
            end
            want.position = POS_W'(pos);
         end else if (entry_count >= insert_limit) begin
            want.status   = STATUS_FULL;
            want.position = '0;
         end else if (find_key(r.key, pos)) begin
            want.status   = STATUS_DUPLICATE;
            want.position = POS_W'(pos);
         end else begin
            for (i = entry_count; i > pos; i--) begin
               keys[i] = keys[i-1];
               vals[i] = vals[i-1];
            end
            keys[pos] = r.key;
            vals[pos] = r.entry_value;
            entry_count++;
            want.status   = STATUS_INSERTED;
            want.position = POS_W'(pos);
         end
         awaited_results.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d position %0d value %h",
                        got.status, got.position, got.found_value);
            return;
         end
         want = awaited_results.pop_front();
         if (got.status !== want.status || got.position !== want.position ||
             got.found_value !== want.found_value) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status %0d position %0d value %h, got %0d %0d %h",
                        want.status, want.position, want.found_value,
                        got.status, got.position, got.found_value);
         end
      endfunction
   endclass

   map_scoreboard table_mirror;

   sorted_key_value_map_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_capacity (csr_capacity)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_sorted_key_value_map_core: FAIL");
         $finish;
      end
   end

   // results cannot be held off, so every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         table_mirror.check_response(rsp_data);
   end

   function automatic int unsigned pick_gap(bit no_idle);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned      r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(0, 99);
      if (table_mirror.entry_count > 0 && r < 35) begin
         k = table_mirror.keys[$urandom_range(0, table_mirror.entry_count - 1)];
      end else if (table_mirror.entry_count > 0 && r < 50) begin
         k = table_mirror.keys[$urandom_range(0, table_mirror.entry_count - 1)];
         k = $urandom_range(0, 1) ? k + 1 : k - 1;
      end else if (r < 55) begin
         k = $urandom_range(0, 1) ? '1 : '0;
      end else if (r < 70) begin
         k = $urandom_range(0, 1000);
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.op          = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_SEARCH;
      r.key         = pick_key();
      r.entry_value = $urandom;
      return r;
   endfunction

   task automatic send_request(req_type r, int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      table_mirror.note_request(r);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (table_mirror.awaited_results.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_capacity <= cap;
      @(posedge clock);
      csr_write_en <= 1'b0;
      table_mirror.set_capacity(cap);
   endtask

   task automatic send_directed(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      req_type r;
      r.op          = op;
      r.key         = k;
      r.entry_value = v;
      send_request(r, pick_gap(1'b0));
   endtask

   logic [CAP_W-1:0] phase_caps  [NUM_PHASES] = '{9'd0, 9'd1, 9'd60, 9'd300,
                                                  9'd130, 9'd511, 9'd256, 9'd200};
   int unsigned      phase_items [NUM_PHASES] = '{60, 60, 250, 150, 120, 800, 100, 60};

   initial begin
      bit no_idle;
      table_mirror = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_capacity = CAPACITY_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then ordered inserts at both ends and the middle
      send_directed(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
      send_directed(OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_directed(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
      send_directed(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_directed(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_directed(OP_INSERT, 32'h8000_0000, 32'h0000_0001);
      send_directed(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
      send_directed(OP_SEARCH, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      send_directed(OP_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_directed(OP_SEARCH, 32'h8000_0001, 32'h0000_0000);
      send_directed(OP_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
      send_directed(OP_INSERT, 32'h0000_0001, 32'h0000_0002);
      send_directed(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
      // capacity below the current fill: full wins over duplicate
      write_capacity(9'd3);
      send_directed(OP_INSERT, 32'h0000_0005, 32'h0000_0005);
      send_directed(OP_INSERT, 32'h0000_0000, 32'h0000_0007);
      send_directed(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
      write_capacity(9'd0);
      send_directed(OP_INSERT, 32'h4000_0000, 32'h0000_0009);
      send_directed(OP_SEARCH, 32'h0000_0001, 32'h0000_0000);
      // above table depth
      write_capacity(9'd511);
      send_directed(OP_INSERT, 32'h4000_0000, 32'hC3C3_C3C3);
      send_directed(OP_INSERT, 32'hFFFF_FFFE, 32'h3C3C_3C3C);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(phase_caps[p]);
         no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_items[p]; n++) begin
            if ($urandom_range(0, 49) == 0)
               no_idle = !no_idle;
            send_request(random_request(), pick_gap(no_idle));
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (table_mirror.mismatches == 0 && table_mirror.awaited_results.size() == 0)
         $display("tb_sorted_key_value_map_core: PASS");
      else
         $display("tb_sorted_key_value_map_core: FAIL");
      $finish;
   end

endmodule
